[rtl/assert_macros.svh]
// Assertion macros shared by the pose solver RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/daps_pkg.sv]
// Package for the dual antenna pose solver: types, constants, CORDIC angle table.
// Depends on nothing; used by daps_cordic and dual_antenna_pose_solver.
package daps_pkg;

   localparam int Iters = 40;
   localparam int BaseW = 46;
   localparam int AngW = 36;
   localparam int RotW = 48;

   localparam logic signed [AngW-1:0] QuarterPi = 36'sd3373259426;
   localparam logic signed [AngW-1:0] HalfPi = 36'sd6746518852;
   localparam logic signed [AngW-1:0] Pi = 36'sd13493037704;
   localparam logic signed [33:0] InvGain = 34'sd2608131496;
   localparam logic signed [19:0] YawMin = -20'sd102944;
   localparam logic signed [19:0] YawMax = 20'sd308832;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_STALE = 2'd1,
      STATUS_COINCIDENT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_TIME_WINDOW = 2'd0,
      CSR_OFFSET_X = 2'd1,
      CSR_OFFSET_Y = 2'd2
   } csr_index_type;

   // Past index 32 the rounded arctangent is one only at index 33, and zero after it.
   function automatic logic signed [AngW-1:0] atan_pow2(input int i);
      logic signed [AngW-1:0] r;
      case (i)
         0: r = 36'sd3373259426;
         1: r = 36'sd1991351318;
         2: r = 36'sd1052175346;
         3: r = 36'sd534100635;
         4: r = 36'sd268086748;
         5: r = 36'sd134174063;
         6: r = 36'sd67103403;
         7: r = 36'sd33553749;
         8: r = 36'sd16777131;
         9: r = 36'sd8388597;
         10: r = 36'sd4194303;
         11: r = 36'sd2097152;
         33: r = 36'sd1;
         default: r = (i > 32) ? '0 : AngW'(64'sd1 << (32 - i));
      endcase
      return r;
   endfunction

endpackage

[rtl/daps_cordic.sv]
// One stage of the CORDIC pipeline, vectoring or rotation mode, with valid bit.
// Depends on daps_pkg for widths and the arctangent table.
module daps_cordic #(
   parameter int Idx = 0,
   parameter int W = 48,
   parameter bit Vectoring = 1'b1,
   parameter int Side = 80
) (
   input  logic clock,
   input  logic reset,
   input  logic valid_in,
   input  logic signed [W-1:0] x_in,
   input  logic signed [W-1:0] y_in,
   input  logic signed [daps_pkg::AngW-1:0] z_in,
   input  logic [Side-1:0] side_in,
   output logic valid_out,
   output logic signed [W-1:0] x_out,
   output logic signed [W-1:0] y_out,
   output logic signed [daps_pkg::AngW-1:0] z_out,
   output logic [Side-1:0] side_out
);
   localparam logic signed [daps_pkg::AngW-1:0] Ang = daps_pkg::atan_pow2(Idx);
   logic valid_ff;
   logic signed [W-1:0] x_ff, y_ff, x_in2, y_in2, xs, ys;
   logic signed [daps_pkg::AngW-1:0] z_ff, z_in2;
   logic [Side-1:0] side_ff;
   logic up;

   always_comb begin
      xs = x_in >>> Idx;
      ys = y_in >>> Idx;
      up = Vectoring ? (y_in >= 0) : (z_in >= 0);
      if (Vectoring ? up : up) begin
         if (Vectoring) begin
            x_in2 = x_in + ys;
            y_in2 = y_in - xs;
         end else begin
            x_in2 = x_in - ys;
            y_in2 = y_in + xs;
         end
         z_in2 = Vectoring ? z_in + Ang : z_in - Ang;
      end else begin
         if (Vectoring) begin
            x_in2 = x_in - ys;
            y_in2 = y_in + xs;
         end else begin
            x_in2 = x_in + ys;
            y_in2 = y_in - xs;
         end
         z_in2 = Vectoring ? z_in - Ang : z_in + Ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff <= x_in2;
      y_ff <= y_in2;
      z_ff <= z_in2;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign side_out = side_ff;
endmodule

[rtl/dual_antenna_pose_solver.sv]
// Top level of the dual antenna pose solver.
// Depends on daps_pkg, daps_cordic and assert_macros.svh.
//
// Use: drive req_* fields with req_start high for one cycle per transfer;
// busy is always low, so a transfer can be issued in every cycle.
// Each transfer gives exactly one result, shown on rsp_* for one cycle with
// rsp_valid high, in the order of the requests.
// The pipeline is a compare and normalize front end of four stages,
// 40 vectoring CORDIC stages, two yaw stages, two offset scaling stages,
// 40 rotation CORDIC stages and two output stages.
// Throughput is one transfer per cycle; every stage above adds to the latency.
// Configuration registers are written through csr_valid/csr_ready with an
// index and data; csr_ready is always high. Write only while idle.
// Synchronous reset clears all valid bits and restores register defaults.
// The receiver cannot stall; results are never held.
`include "assert_macros.svh"
module dual_antenna_pose_solver (
   input  logic clock,
   input  logic reset,
   input  logic req_start,
   output logic busy,
   input  logic signed [31:0] req_left_x,
   input  logic signed [31:0] req_left_y,
   input  logic [47:0] req_left_time,
   input  logic signed [31:0] req_right_x,
   input  logic signed [31:0] req_right_y,
   input  logic [47:0] req_right_time,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [19:0] rsp_yaw
);
   localparam int N = daps_pkg::Iters;
   localparam int BW = daps_pkg::BaseW;
   localparam int AW = daps_pkg::AngW;
   localparam int RW = daps_pkg::RotW;

   logic [31:0] window_ff;
   logic signed [20:0] offx_ff, offy_ff;

   assign csr_ready = 1'b1;
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 32'd200000;
         offx_ff <= -21'sd4872;
         offy_ff <= -21'sd5844;
      end else if (csr_valid) begin
         case (csr_index)
            daps_pkg::CSR_TIME_WINDOW: window_ff <= csr_data;
            daps_pkg::CSR_OFFSET_X: offx_ff <= csr_data[20:0];
            daps_pkg::CSR_OFFSET_Y: offy_ff <= csr_data[20:0];
            default: ;
         endcase
      end
   end

   // Stage 1: differences.
   logic v1_ff;
   logic [47:0] tdiff1_ff;
   logic signed [32:0] dx1_ff, dy1_ff;
   logic signed [31:0] rx1_ff, ry1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_start;
      end
      tdiff1_ff <= (req_left_time > req_right_time) ? req_left_time - req_right_time
                                                    : req_right_time - req_left_time;
      dx1_ff <= 33'(req_right_x) - 33'(req_left_x);
      dy1_ff <= 33'(req_right_y) - 33'(req_left_y);
      rx1_ff <= req_right_x;
      ry1_ff <= req_right_y;
   end

   // Stage 2: status and quadrant turn.
   logic v2_ff;
   logic [1:0] st2_ff;
   logic signed [33:0] x2_ff, y2_ff;
   logic signed [AW-1:0] z2_ff;
   logic signed [31:0] rx2_ff, ry2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      if (tdiff1_ff >= 48'(window_ff)) begin
         st2_ff <= daps_pkg::STATUS_STALE;
      end else if (dx1_ff == 0 && dy1_ff == 0) begin
         st2_ff <= daps_pkg::STATUS_COINCIDENT;
      end else begin
         st2_ff <= daps_pkg::STATUS_OK;
      end
      if (dx1_ff < 0 && dy1_ff >= 0) begin
         x2_ff <= 34'(dy1_ff);
         y2_ff <= -34'(dx1_ff);
         z2_ff <= daps_pkg::HalfPi;
      end else if (dx1_ff < 0) begin
         x2_ff <= -34'(dy1_ff);
         y2_ff <= 34'(dx1_ff);
         z2_ff <= -daps_pkg::HalfPi;
      end else begin
         x2_ff <= 34'(dx1_ff);
         y2_ff <= 34'(dy1_ff);
         z2_ff <= '0;
      end
      rx2_ff <= rx1_ff;
      ry2_ff <= ry1_ff;
   end

   // Stage 3: magnitude and shift count.
   logic v3_ff;
   logic [1:0] st3_ff;
   logic signed [33:0] x3_ff, y3_ff;
   logic signed [AW-1:0] z3_ff;
   logic [5:0] sh3_ff;
   logic signed [31:0] rx3_ff, ry3_ff;
   logic [33:0] ax2, ay2, m2;
   logic [5:0] sh2;
   always_comb begin
      ax2 = x2_ff < 0 ? 34'(-x2_ff) : 34'(x2_ff);
      ay2 = y2_ff < 0 ? 34'(-y2_ff) : 34'(y2_ff);
      m2 = ax2 > ay2 ? ax2 : ay2;
      sh2 = 6'd40;
      for (int b = 0; b < 34; b++) begin
         if (m2[b]) sh2 = 6'(40 - b);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      st3_ff <= st2_ff;
      x3_ff <= x2_ff;
      y3_ff <= y2_ff;
      z3_ff <= z2_ff;
      sh3_ff <= sh2;
      rx3_ff <= rx2_ff;
      ry3_ff <= ry2_ff;
   end

   // Stage 4: normalize.
   logic v4_ff;
   logic signed [BW-1:0] x4_ff, y4_ff;
   logic signed [AW-1:0] z4_ff;
   logic [81:0] side4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      x4_ff <= BW'(x3_ff) <<< sh3_ff;
      y4_ff <= BW'(y3_ff) <<< sh3_ff;
      z4_ff <= z3_ff;
      side4_ff <= {16'd0, st3_ff, rx3_ff, ry3_ff};
   end

   logic vv [0:N];
   logic signed [BW-1:0] vx [0:N];
   logic signed [BW-1:0] vy [0:N];
   logic signed [AW-1:0] vz [0:N];
   logic [81:0] vs [0:N];
   assign vv[0] = v4_ff;
   assign vx[0] = x4_ff;
   assign vy[0] = y4_ff;
   assign vz[0] = z4_ff;
   assign vs[0] = side4_ff;
   for (genvar g = 0; g < N; g++) begin : g_vec
      daps_cordic #(.Idx(g), .W(BW), .Vectoring(1'b1), .Side(82)) u_stage (
         .clock(clock), .reset(reset), .valid_in(vv[g]),
         .x_in(vx[g]), .y_in(vy[g]), .z_in(vz[g]), .side_in(vs[g]),
         .valid_out(vv[g+1]), .x_out(vx[g+1]), .y_out(vy[g+1]),
         .z_out(vz[g+1]), .side_out(vs[g+1])
      );
   end

   // Yaw stage A: round.
   logic v5_ff;
   logic signed [AW-1:0] yr5_ff;
   logic [81:0] s5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= vv[N];
      end
      yr5_ff <= (vz[N] + daps_pkg::HalfPi + AW'(64'sd32768)) >>> 16;
      s5_ff <= vs[N];
   end

   // Yaw stage B: clamp and fold to [-pi/2, pi/2].
   logic v6_ff;
   logic signed [19:0] yaw6_ff;
   logic signed [AW-1:0] z6_ff;
   logic neg6_ff;
   logic [81:0] s6_ff;
   logic signed [19:0] yc5;
   logic signed [AW-1:0] zq5;
   always_comb begin
      if (yr5_ff < AW'(daps_pkg::YawMin)) yc5 = daps_pkg::YawMin;
      else if (yr5_ff > AW'(daps_pkg::YawMax)) yc5 = daps_pkg::YawMax;
      else yc5 = yr5_ff[19:0];
      zq5 = AW'(yc5) <<< 16;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      yaw6_ff <= yc5;
      if (zq5 > daps_pkg::HalfPi) begin
         z6_ff <= zq5 - daps_pkg::Pi;
         neg6_ff <= 1'b1;
      end else if (zq5 < -daps_pkg::HalfPi) begin
         z6_ff <= zq5 + daps_pkg::Pi;
         neg6_ff <= 1'b1;
      end else begin
         z6_ff <= zq5;
         neg6_ff <= 1'b0;
      end
      s6_ff <= s5_ff;
   end

   // Offset scaling: negate when the angle was folded, then multiply by inverse gain.
   logic v7_ff;
   logic signed [21:0] ox7_ff, oy7_ff;
   logic signed [AW-1:0] z7_ff;
   logic [81:0] s7_ff;
   logic signed [19:0] yaw7_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      ox7_ff <= neg6_ff ? -22'(offx_ff) : 22'(offx_ff);
      oy7_ff <= neg6_ff ? -22'(offy_ff) : 22'(offy_ff);
      z7_ff <= z6_ff;
      s7_ff <= s6_ff;
      yaw7_ff <= yaw6_ff;
   end

   logic v8_ff;
   logic signed [RW-1:0] x8_ff, y8_ff;
   logic signed [AW-1:0] z8_ff;
   logic [81:0] s8_ff;
   logic signed [55:0] px7, py7;
   assign px7 = 56'(ox7_ff) * 56'(daps_pkg::InvGain);
   assign py7 = 56'(oy7_ff) * 56'(daps_pkg::InvGain);
   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
      x8_ff <= RW'(px7 >>> 12);
      y8_ff <= RW'(py7 >>> 12);
      z8_ff <= z7_ff;
      s8_ff <= {yaw7_ff[15:0], s7_ff[65:64], s7_ff[63:0]};
   end

   logic rv [0:N];
   logic signed [RW-1:0] rx [0:N];
   logic signed [RW-1:0] ry [0:N];
   logic signed [AW-1:0] rz [0:N];
   logic [85:0] rs [0:N];
   logic [3:0] yaw_top8_ff;
   always_ff @(posedge clock) begin
      yaw_top8_ff <= yaw7_ff[19:16];
   end
   assign rv[0] = v8_ff;
   assign rx[0] = x8_ff;
   assign ry[0] = y8_ff;
   assign rz[0] = z8_ff;
   assign rs[0] = {yaw_top8_ff, s8_ff};
   for (genvar g = 0; g < N; g++) begin : g_rot
      daps_cordic #(.Idx(g), .W(RW), .Vectoring(1'b0), .Side(86)) u_stage (
         .clock(clock), .reset(reset), .valid_in(rv[g]),
         .x_in(rx[g]), .y_in(ry[g]), .z_in(rz[g]), .side_in(rs[g]),
         .valid_out(rv[g+1]), .x_out(rx[g+1]), .y_out(ry[g+1]),
         .z_out(rz[g+1]), .side_out(rs[g+1])
      );
   end

   // Output stage A: round rotated offset.
   logic v9_ff;
   logic signed [RW-21:0] ox9_ff, oy9_ff;
   logic [85:0] s9_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= rv[N];
      end
      ox9_ff <= (RW-20)'((rx[N] + RW'(64'sd524288)) >>> 20);
      oy9_ff <= (RW-20)'((ry[N] + RW'(64'sd524288)) >>> 20);
      s9_ff <= rs[N];
   end

   // Output stage B: subtract, saturate, select.
   logic signed [33:0] dpx, dpy;
   logic signed [31:0] rxs, rys, satx, saty;
   logic [1:0] st9;
   assign rxs = s9_ff[63:32];
   assign rys = s9_ff[31:0];
   assign st9 = s9_ff[65:64];
   always_comb begin
      dpx = 34'(rxs) - 34'(ox9_ff);
      dpy = 34'(rys) - 34'(oy9_ff);
      if (dpx > 34'sd2147483647) satx = 32'sh7FFFFFFF;
      else if (dpx < -34'sd2147483648) satx = 32'sh80000000;
      else satx = dpx[31:0];
      if (dpy > 34'sd2147483647) saty = 32'sh7FFFFFFF;
      else if (dpy < -34'sd2147483648) saty = 32'sh80000000;
      else saty = dpy[31:0];
   end

   logic v10_ff;
   logic [1:0] st10_ff;
   logic signed [31:0] px10_ff, py10_ff;
   logic signed [19:0] yaw10_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= v9_ff;
      end
      st10_ff <= st9;
      if (st9 == daps_pkg::STATUS_OK) begin
         px10_ff <= satx;
         py10_ff <= saty;
         yaw10_ff <= {s9_ff[85:82], s9_ff[81:66]};
      end else begin
         px10_ff <= '0;
         py10_ff <= '0;
         yaw10_ff <= '0;
      end
   end

   assign rsp_valid = v10_ff;
   assign rsp_status = st10_ff;
   assign rsp_pos_x = px10_ff;
   assign rsp_pos_y = py10_ff;
   assign rsp_yaw = yaw10_ff;

   `ASSERT_IMPLIES(a_status_range, clock, reset, rsp_valid, rsp_status != 2'd3)
   `ASSERT_IMPLIES(a_zero_unless_ok, clock, reset,
      rsp_valid && rsp_status != daps_pkg::STATUS_OK, rsp_pos_x == 0 && rsp_yaw == 0)
   `ASSERT_NEXT(a_front_valid, clock, reset, req_start, v1_ff)
endmodule

[bench/dual_antenna_pose_solver_tb.sv]
// Testbench for the dual antenna pose solver: directed table, then random pairs.
// Depends on daps_pkg and dual_antenna_pose_solver; results checked against a local predictor.
`timescale 1ns / 100ps
module dual_antenna_pose_solver_tb;

   localparam logic [1:0] CSR_UNMAPPED = 2'd3;
   localparam int SettleCycles = 100;

   typedef struct {
      logic signed [31:0] lx, ly, rx, ry;
      logic [47:0] lt, rt;
   } pair_type;

   typedef struct {
      daps_pkg::status_type status;
      logic signed [31:0] pos_x, pos_y;
      logic signed [19:0] yaw;
   } pose_type;

   typedef struct {
      pair_type pair;
      bit typed;
      pose_type pose;
   } row_type;

   logic clock = 0, reset = 1, req_start = 0, busy;
   logic signed [31:0] req_left_x = 0, req_left_y = 0, req_right_x = 0, req_right_y = 0;
   logic [47:0] req_left_time = 0, req_right_time = 0;
   logic csr_valid = 0, csr_ready;
   logic [1:0] csr_index = daps_pkg::CSR_TIME_WINDOW;
   logic [31:0] csr_data = 0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_pos_x, rsp_pos_y;
   logic signed [19:0] rsp_yaw;

   dual_antenna_pose_solver dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   longint unsigned window_us;
   longint off_x, off_y;
   longint atan_q32 [daps_pkg::Iters];
   pose_type pending_poses [$];
   int failures = 0, checked = 0, sent = 0;

   function automatic longint arctan_term(int i);
      longint acc, term;
      int e;
      if (i == 0) return longint'(daps_pkg::QuarterPi);
      acc = 0;
      for (int k = 0; ; k++) begin
         e = 62 - i * (2 * k + 1);
         if (e < 0) break;
         term = longint'((64'd1 << e) / (2 * k + 1));
         if (k % 2) acc -= term; else acc += term;
      end
      return (acc + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic pose_type predict_pose(pair_type p);
      pose_type r;
      longint unsigned diff;
      longint dx, dy, x, y, z, nx, ny, ax, ay, m, yv, ox, oy, px, py;
      int s;
      r.status = daps_pkg::STATUS_OK; r.pos_x = 0; r.pos_y = 0; r.yaw = 0;
      diff = (p.lt > p.rt) ? p.lt - p.rt : p.rt - p.lt;
      if (diff >= window_us) begin
         r.status = daps_pkg::STATUS_STALE;
         return r;
      end
      dx = longint'(p.rx) - longint'(p.lx);
      dy = longint'(p.ry) - longint'(p.ly);
      if (dx == 0 && dy == 0) begin
         r.status = daps_pkg::STATUS_COINCIDENT;
         return r;
      end
      x = dx; y = dy; z = 0;
      if (dx < 0 && dy >= 0) begin
         x = dy; y = -dx; z = longint'(daps_pkg::HalfPi);
      end else if (dx < 0) begin
         x = -dy; y = dx; z = -longint'(daps_pkg::HalfPi);
      end
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      m = ax > ay ? ax : ay;
      s = 0;
      while (m < (64'sd1 <<< 40)) begin
         m = m * 2; s++;
      end
      x = x * (64'sd1 <<< s);
      y = y * (64'sd1 <<< s);
      for (int i = 0; i < daps_pkg::Iters; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q32[i];
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q32[i];
         end
         x = nx; y = ny;
      end
      yv = (z + longint'(daps_pkg::HalfPi) + (64'sd1 <<< 15)) >>> 16;
      if (yv < longint'(daps_pkg::YawMin)) yv = longint'(daps_pkg::YawMin);
      if (yv > longint'(daps_pkg::YawMax)) yv = longint'(daps_pkg::YawMax);
      z = yv * 65536; ox = off_x; oy = off_y;
      if (z > longint'(daps_pkg::HalfPi)) begin
         z -= longint'(daps_pkg::Pi); ox = -ox; oy = -oy;
      end else if (z < -longint'(daps_pkg::HalfPi)) begin
         z += longint'(daps_pkg::Pi); ox = -ox; oy = -oy;
      end
      x = (ox * longint'(daps_pkg::InvGain)) >>> 12;
      y = (oy * longint'(daps_pkg::InvGain)) >>> 12;
      for (int i = 0; i < daps_pkg::Iters; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q32[i];
         end else begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q32[i];
         end
         x = nx; y = ny;
      end
      ox = (x + (64'sd1 <<< 19)) >>> 20;
      oy = (y + (64'sd1 <<< 19)) >>> 20;
      px = longint'(p.rx) - ox;
      py = longint'(p.ry) - oy;
      if (px > 64'sd2147483647) px = 64'sd2147483647;
      if (px < -64'sd2147483648) px = -64'sd2147483648;
      if (py > 64'sd2147483647) py = 64'sd2147483647;
      if (py < -64'sd2147483648) py = -64'sd2147483648;
      r.pos_x = px[31:0]; r.pos_y = py[31:0]; r.yaw = yv[19:0];
      return r;
   endfunction

   function automatic pair_type make_pair(longint lx, longint ly, longint lt,
                                          longint rx, longint ry, longint rt);
      pair_type p;
      p.lx = lx[31:0]; p.ly = ly[31:0]; p.lt = lt[47:0];
      p.rx = rx[31:0]; p.ry = ry[31:0]; p.rt = rt[47:0];
      return p;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int kind, span;
      logic [47:0] gap;
      kind = $urandom_range(0, 99);
      span = $urandom_range(0, 31);
      p.lt = {16'($urandom), 32'($urandom)};
      gap = 48'($urandom_range(0, 260000));
      p.rt = $urandom_range(0, 1) ? p.lt + gap : p.lt - gap;
      p.lx = $urandom; p.ly = $urandom;
      p.rx = p.lx + ($signed($urandom) >>> span);
      p.ry = p.ly + ($signed($urandom) >>> span);
      if (kind >= 90) begin
         p.rt = {16'($urandom), 32'($urandom)};
      end else if (kind >= 86) begin
         p.rx = p.lx;
      end else if (kind >= 82) begin
         p.ry = p.ly;
      end else if (kind >= 78) begin
         p.rx = p.lx; p.ry = p.ly;
      end else if (kind >= 70) begin
         p.rx = $urandom; p.ry = $urandom;
      end
      return p;
   endfunction

   task automatic issue_pair(pair_type p, int idle_pct);
      @(negedge clock);
      req_left_x <= p.lx; req_left_y <= p.ly; req_left_time <= p.lt;
      req_right_x <= p.rx; req_right_y <= p.ry; req_right_time <= p.rt;
      req_start <= 1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_poses.push_back(predict_pose(p));
      sent++;
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_start <= 0;
      end
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_start <= 0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         daps_pkg::CSR_TIME_WINDOW: window_us = data;
         daps_pkg::CSR_OFFSET_X: off_x = longint'($signed(data[20:0]));
         daps_pkg::CSR_OFFSET_Y: off_y = longint'($signed(data[20:0]));
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   always @(posedge clock) begin
      pose_type want;
      if (!reset && rsp_valid) begin
         if (pending_poses.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, rsp_status);
            failures++;
         end else begin
            want = pending_poses.pop_front();
            checked++;
            if (rsp_status !== want.status || rsp_pos_x !== want.pos_x
                || rsp_pos_y !== want.pos_y || rsp_yaw !== want.yaw) begin
               $display("%0t: expected status %0d pos (%0d, %0d) yaw %0d", $time,
                        want.status, want.pos_x, want.pos_y, want.yaw);
               $display("%0t: actual   status %0d pos (%0d, %0d) yaw %0d", $time,
                        rsp_status, rsp_pos_x, rsp_pos_y, rsp_yaw);
               failures++;
            end
         end
      end
   end

   initial begin
      row_type rows [$];
      row_type row;
      int idle_pct [5] = '{35, 82, 0, 20, 15};
      int count [5] = '{300, 300, 300, 40, 300};
      for (int i = 0; i < daps_pkg::Iters; i++) atan_q32[i] = arctan_term(i);
      window_us = 200000; off_x = -4872; off_y = -5844;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      row.typed = 1;
      row.pose = '{daps_pkg::STATUS_STALE, 0, 0, 0};
      row.pair = make_pair(0, 0, 0, 100, 100, 200000);
      rows.push_back(row);
      row.pair = make_pair(-2147483648, 2147483647, 0, 5, 5, 48'hFFFF_FFFF_FFFF);
      rows.push_back(row);
      row.pose = '{daps_pkg::STATUS_COINCIDENT, 0, 0, 0};
      row.pair = make_pair(1234, -99, 500, 1234, -99, 500);
      rows.push_back(row);
      row.pair = make_pair(-2147483648, -2147483648, 48'hFFFF_FFFF_FFFF,
                           -2147483648, -2147483648, 48'hFFFF_FFFF_FFFF);
      rows.push_back(row);
      row.typed = 0;
      row.pair = make_pair(0, 0, 1000, -50000, 0, 1000);
      rows.push_back(row);
      row.pair = make_pair(2147483647, 0, 10, -2147483648, 0, 199999 + 10);
      rows.push_back(row);
      row.pair = make_pair(0, 0, 0, 1, 0, 0);
      rows.push_back(row);
      row.pair = make_pair(0, 0, 0, 0, 1, 0);
      rows.push_back(row);
      row.pair = make_pair(0, 0, 0, 0, -1, 0);
      rows.push_back(row);
      row.pair = make_pair(0, 0, 0, -1, -1, 0);
      rows.push_back(row);
      row.pair = make_pair(-2147483648, -2147483648, 7, 2147483647, 2147483647, 7);
      rows.push_back(row);
      row.pair = make_pair(2147483647, 2147483647, 7, -2147483648, -2147483648, 7);
      rows.push_back(row);
      row.pair = make_pair(0, 0, 0, 2147483647, -2147483648, 0);
      rows.push_back(row);
      row.pair = make_pair(-3, 4, 20, 2147483647, 2147483647, 0);
      rows.push_back(row);
      foreach (rows[i]) begin
         if (rows[i].typed && predict_pose(rows[i].pair) != rows[i].pose) begin
            $display("%0t: table row %0d disagrees with predictor", $time, i);
            failures++;
         end
         issue_pair(rows[i].pair, 0);
         if (rows[i].typed) pending_poses[$] = rows[i].pose;
      end
      drain_pipeline();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            1: begin
               write_csr(daps_pkg::CSR_TIME_WINDOW, 32'hFFFF_FFFF);
               write_csr(daps_pkg::CSR_OFFSET_X, 32'(1000000));
               write_csr(daps_pkg::CSR_OFFSET_Y, 32'(-1000000));
               write_csr(CSR_UNMAPPED, $urandom);
               for (int j = 0; j < 6; j++)
                  issue_pair(make_pair(2147483647 - j, -2147483648 + j, 0,
                                       2147483647, -2147483648, 0), 0);
            end
            2: begin
               write_csr(daps_pkg::CSR_TIME_WINDOW, $urandom_range(1, 300000));
               write_csr(daps_pkg::CSR_OFFSET_X,
                         {11'($urandom), 21'($urandom_range(0, 2000000) - 1000000)});
               write_csr(daps_pkg::CSR_OFFSET_Y,
                         {11'($urandom), 21'($urandom_range(0, 2000000) - 1000000)});
            end
            3: write_csr(daps_pkg::CSR_TIME_WINDOW, 0);
            4: begin
               write_csr(daps_pkg::CSR_TIME_WINDOW, 200000);
               write_csr(daps_pkg::CSR_OFFSET_X, 32'(-1000000));
               write_csr(daps_pkg::CSR_OFFSET_Y, 32'(1000000));
            end
            default: ;
         endcase
         for (int n = 0; n < count[ph]; n++) begin
            issue_pair(random_pair(), idle_pct[ph]);
            if (ph == 0 && n == 150) drain_pipeline();
         end
         drain_pipeline();
      end

      $display("Sent %0d pairs over five register settings; %0d results compared.",
               sent, checked);
      if (failures == 0 && pending_poses.size() == 0)
         $display("dual_antenna_pose_solver_tb passed");
      else
         $display("dual_antenna_pose_solver_tb failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("dual_antenna_pose_solver_tb failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/daps_pkg.sv
rtl/daps_cordic.sv
rtl/dual_antenna_pose_solver.sv
bench/dual_antenna_pose_solver_tb.sv
